// File: src/oave_pkg.sv
package oave_pkg;

  localparam int DEF_MAX_PACKET = 1536;
  localparam int DEF_MAX_NAME   = 32;
  localparam int DEF_MAX_DEPTH  = 8;

  localparam int NAME_REGS = 4;

  localparam logic [2:0] CFG_NAME_LENGTH = 3'd0;
  localparam logic [2:0] CFG_NAME_CHARS0 = 3'd1;
  localparam logic [2:0] CFG_NAME_CHARS1 = 3'd2;
  localparam logic [2:0] CFG_NAME_CHARS2 = 3'd3;
  localparam logic [2:0] CFG_NAME_CHARS3 = 3'd4;

  localparam logic [5:0]  RST_NAME_LENGTH = 6'd6;
  localparam logic [63:0] RST_NAME_CHARS0 = 64'd54350150394671;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_F     = 8'h66;
  localparam logic [7:0] CHAR_I     = 8'h69;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef logic [NAME_REGS-1:0][63:0] name_chars_t;

  typedef struct packed {
    logic [5:0]  name_length;
    name_chars_t name_chars;
  } name_cfg_t;

  typedef struct packed {
    logic        ok;
    logic        is_int;
    logic [31:0] raw;
  } parse_res_t;

  function automatic logic [7:0] bundle_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0: c = 8'h23;
      3'd1: c = 8'h62;
      3'd2: c = 8'h75;
      3'd3: c = 8'h6E;
      3'd4: c = 8'h64;
      3'd5: c = 8'h6C;
      3'd6: c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] name_char(input name_chars_t chars, input logic [4:0] k);
    return chars[k[4:3]][{k[2:0], 3'b000} +: 8];
  endfunction

endpackage

// File: src/oave_if.sv
interface oave_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;
  modport source (output valid, packet_byte, last_byte, input ready);
  modport sink (input valid, packet_byte, last_byte, output ready);
endinterface

interface oave_out_if;
  logic        valid;
  logic        ready;
  logic        updated;
  logic [31:0] value_bits;
  modport source (output valid, updated, value_bits, input ready);
  modport sink (input valid, updated, value_bits, output ready);
endinterface

interface oave_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/oave_cfg_regs.sv
module oave_cfg_regs
  import oave_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  oave_cfg_if.sink  cfg,
  output name_cfg_t name_cfg
);

  logic [5:0]  name_length;
  name_chars_t name_chars;

  assign cfg.ready = 1'b1;
  assign name_cfg.name_length = name_length;
  assign name_cfg.name_chars  = name_chars;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_length   <= RST_NAME_LENGTH;
      name_chars[0] <= RST_NAME_CHARS0;
      name_chars[1] <= '0;
      name_chars[2] <= '0;
      name_chars[3] <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_NAME_LENGTH: name_length <= cfg.data[5:0];
        CFG_NAME_CHARS0: name_chars[0] <= cfg.data;
        CFG_NAME_CHARS1: name_chars[1] <= cfg.data;
        CFG_NAME_CHARS2: name_chars[2] <= cfg.data;
        CFG_NAME_CHARS3: name_chars[3] <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// File: src/oave_parser.sv
module oave_parser
  import oave_pkg::*;
#(
  parameter int MAX_PACKET = DEF_MAX_PACKET,
  parameter int MAX_NAME   = DEF_MAX_NAME,
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  oave_in_if.sink    stream,
  input  name_cfg_t  name_cfg,
  output parse_res_t res,
  output logic       res_valid,
  input  logic       res_ready
);

  localparam int CW = $clog2(MAX_PACKET + 1);
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [CW-1:0] PKT_LIMIT = CW'(MAX_PACKET);
  localparam logic [LW-1:0] DEPTH_LIMIT = LW'(MAX_DEPTH);

  localparam logic [3:0] PH_ADDR     = 4'd0;
  localparam logic [3:0] PH_ADDR_PAD = 4'd1;
  localparam logic [3:0] PH_TAG0     = 4'd2;
  localparam logic [3:0] PH_TAG1     = 4'd3;
  localparam logic [3:0] PH_TAGS     = 4'd4;
  localparam logic [3:0] PH_TAG_PAD  = 4'd5;
  localparam logic [3:0] PH_ARG      = 4'd6;
  localparam logic [3:0] PH_TIME     = 4'd7;
  localparam logic [3:0] PH_SIZE     = 4'd8;
  localparam logic [3:0] PH_SKIP     = 4'd9;

  // input register
  logic       ib_valid;
  logic [7:0] ib_byte;
  logic       ib_last;
  logic       consume;

  // parse state
  logic [CW-1:0] bytes_taken, bytes_taken_next;
  logic [LW-1:0] nesting_level, nesting_level_next;
  logic [3:0]    parse_phase, parse_phase_next;
  logic [3:0]    element_position, element_position_next;
  logic [5:0]    name_compare_position, name_compare_position_next;
  logic          bundle_ok, bundle_ok_next;
  logic          direct_ok, direct_ok_next;
  logic          slash_ok, slash_ok_next;
  logic [7:0]    first_tag_char, first_tag_char_next;
  logic [23:0]   word_shift, word_shift_next;
  logic [CW-1:0] cur_left, cur_left_next;
  logic [CW-1:0] level_bytes_left [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] level_live;
  logic          any_matched, any_matched_next;
  logic [31:0]   candidate_value, candidate_value_next;
  logic          candidate_int, candidate_int_next;
  logic          pend_any, pend_any_next;
  logic [31:0]   pend_value, pend_value_next;
  logic          pend_int, pend_int_next;

  logic          push;
  logic [SW-1:0] push_idx;
  logic [CW-1:0] push_left;
  logic [SW-1:0] pop_idx;

  logic [5:0]  nlen;
  logic [7:0]  ch_direct, ch_slash, ch_first;
  logic        bounded, ends, hit, addr_ok, size_bad;
  logic [CW-1:0] left_dec, child_left;
  logic [31:0] esize, hit_raw;

  assign consume      = ib_valid && (!ib_last || !res_valid || res_ready);
  assign stream.ready = !ib_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (stream.ready) begin
      ib_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      ib_byte <= stream.packet_byte;
      ib_last <= stream.last_byte;
    end
  end

  assign nlen = (name_cfg.name_length > 6'(MAX_NAME)) ? 6'(MAX_NAME) : name_cfg.name_length;
  assign ch_direct = name_char(name_cfg.name_chars, name_compare_position[4:0]);
  assign ch_slash  = name_char(name_cfg.name_chars, name_compare_position[4:0] - 5'd1);
  assign ch_first  = name_char(name_cfg.name_chars, 5'd0);

  assign bounded    = nesting_level != '0;
  assign left_dec   = cur_left - CW'(1);
  assign ends       = bounded && (left_dec == '0);
  assign esize      = {word_shift, ib_byte};
  assign hit_raw    = {word_shift, ib_byte};
  assign child_left = (|esize[31:CW]) ? '1 : esize[CW-1:0];
  assign size_bad   = (esize == '0) || (bounded && (esize > 32'(left_dec)));
  assign addr_ok    = (nlen != '0) &&
                      (((name_compare_position == nlen) && direct_ok) ||
                       ((ch_first != CHAR_SLASH) && (name_compare_position == nlen + 6'd1) &&
                        slash_ok));

  always_comb begin
    pop_idx = '0;
    for (int d = 0; d < MAX_DEPTH; d++) begin
      if ((LW'(d) < nesting_level) && ((d == 0) || level_live[d])) begin
        pop_idx = SW'(d);
      end
    end
  end

  always_comb begin
    bytes_taken_next           = bytes_taken;
    nesting_level_next         = nesting_level;
    parse_phase_next           = parse_phase;
    element_position_next      = element_position + 4'd1;
    name_compare_position_next = name_compare_position;
    bundle_ok_next             = bundle_ok;
    direct_ok_next             = direct_ok;
    slash_ok_next              = slash_ok;
    first_tag_char_next        = first_tag_char;
    word_shift_next            = word_shift;
    cur_left_next              = bounded ? left_dec : cur_left;
    any_matched_next           = any_matched;
    candidate_value_next       = candidate_value;
    candidate_int_next         = candidate_int;
    pend_any_next              = pend_any;
    pend_value_next            = pend_value;
    pend_int_next              = pend_int;
    push                       = 1'b0;
    push_idx                   = nesting_level[SW-1:0];
    push_left                  = left_dec - esize[CW-1:0];
    hit                        = 1'b0;

    if (bytes_taken < PKT_LIMIT) begin
      bytes_taken_next = bytes_taken + CW'(1);
      case (parse_phase)
        PH_ADDR: begin
          if (element_position == 4'd7 && bundle_ok) begin
            parse_phase_next = (nesting_level >= DEPTH_LIMIT) ? PH_SKIP : PH_TIME;
          end else begin
            if (!element_position[3] && element_position[2:0] != 3'd7) begin
              bundle_ok_next = bundle_ok && (ib_byte == bundle_char(element_position[2:0]));
            end
            if (ib_byte == 8'h00) begin
              if (!addr_ok) begin
                parse_phase_next = PH_SKIP;
              end else begin
                parse_phase_next = (element_position[1:0] == 2'd3) ? PH_TAG0 : PH_ADDR_PAD;
              end
            end else begin
              direct_ok_next = direct_ok &&
                               ((name_compare_position >= nlen) || (ib_byte == ch_direct));
              slash_ok_next  = slash_ok &&
                               ((name_compare_position == '0) ? (ib_byte == CHAR_SLASH) :
                                ((name_compare_position > nlen) || (ib_byte == ch_slash)));
              if (name_compare_position != 6'h3F) begin
                name_compare_position_next = name_compare_position + 6'd1;
              end
            end
          end
        end
        PH_ADDR_PAD: begin
          if (element_position[1:0] == 2'd3) parse_phase_next = PH_TAG0;
        end
        PH_TAG0: begin
          parse_phase_next = (ib_byte == CHAR_COMMA) ? PH_TAG1 : PH_SKIP;
        end
        PH_TAG1: begin
          first_tag_char_next = ib_byte;
          parse_phase_next = (ib_byte == CHAR_F || ib_byte == CHAR_I) ? PH_TAGS : PH_SKIP;
        end
        PH_TAGS: begin
          if (ib_byte == 8'h00) begin
            parse_phase_next = (element_position[1:0] == 2'd3) ? PH_ARG : PH_TAG_PAD;
          end
        end
        PH_TAG_PAD: begin
          if (element_position[1:0] == 2'd3) parse_phase_next = PH_ARG;
        end
        PH_ARG: begin
          word_shift_next = {word_shift[15:0], ib_byte};
          if (element_position[1:0] == 2'd3) begin
            hit = 1'b1;
            parse_phase_next = PH_SKIP;
          end
        end
        PH_TIME: begin
          if (element_position == 4'd15) begin
            parse_phase_next = PH_SIZE;
            element_position_next = '0;
          end
        end
        PH_SIZE: begin
          word_shift_next = {word_shift[15:0], ib_byte};
          if (element_position[1:0] == 2'd3) begin
            if (size_bad) begin
              parse_phase_next = PH_SKIP;
            end else begin
              push                       = 1'b1;
              nesting_level_next         = nesting_level + LW'(1);
              cur_left_next              = child_left;
              parse_phase_next           = PH_ADDR;
              element_position_next      = '0;
              name_compare_position_next = '0;
              bundle_ok_next             = 1'b1;
              direct_ok_next             = 1'b1;
              slash_ok_next              = 1'b1;
            end
          end
        end
        PH_SKIP: ;
        default: parse_phase_next = PH_SKIP;
      endcase

      if (hit) begin
        if (bounded) begin
          pend_any_next   = 1'b1;
          pend_value_next = hit_raw;
          pend_int_next   = (first_tag_char == CHAR_I);
        end else begin
          any_matched_next     = 1'b1;
          candidate_value_next = hit_raw;
          candidate_int_next   = (first_tag_char == CHAR_I);
        end
      end

      // element closes: resume the innermost parent with bytes left
      if (ends) begin
        push                  = 1'b0;
        nesting_level_next    = LW'(pop_idx);
        cur_left_next         = level_bytes_left[pop_idx];
        parse_phase_next      = PH_SIZE;
        element_position_next = '0;
        if (pop_idx == '0) begin
          if (pend_any_next) begin
            any_matched_next     = 1'b1;
            candidate_value_next = pend_value_next;
            candidate_int_next   = pend_int_next;
          end
          pend_any_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (consume && ib_last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && ib_last) begin
      res.ok     <= any_matched_next;
      res.raw    <= candidate_value_next;
      res.is_int <= candidate_int_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_taken           <= '0;
      nesting_level         <= '0;
      parse_phase           <= PH_ADDR;
      element_position      <= '0;
      name_compare_position <= '0;
      bundle_ok             <= 1'b1;
      direct_ok             <= 1'b1;
      slash_ok              <= 1'b1;
      any_matched           <= 1'b0;
      pend_any              <= 1'b0;
    end else if (consume) begin
      if (ib_last) begin
        bytes_taken           <= '0;
        nesting_level         <= '0;
        parse_phase           <= PH_ADDR;
        element_position      <= '0;
        name_compare_position <= '0;
        bundle_ok             <= 1'b1;
        direct_ok             <= 1'b1;
        slash_ok              <= 1'b1;
        any_matched           <= 1'b0;
        pend_any              <= 1'b0;
      end else begin
        bytes_taken           <= bytes_taken_next;
        nesting_level         <= nesting_level_next;
        parse_phase           <= parse_phase_next;
        element_position      <= element_position_next;
        name_compare_position <= name_compare_position_next;
        bundle_ok             <= bundle_ok_next;
        direct_ok             <= direct_ok_next;
        slash_ok              <= slash_ok_next;
        any_matched           <= any_matched_next;
        pend_any              <= pend_any_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      first_tag_char  <= first_tag_char_next;
      word_shift      <= word_shift_next;
      cur_left        <= cur_left_next;
      candidate_value <= candidate_value_next;
      candidate_int   <= candidate_int_next;
      pend_value      <= pend_value_next;
      pend_int        <= pend_int_next;
      if (push) begin
        level_bytes_left[push_idx] <= push_left;
        level_live[push_idx]       <= !bounded || (push_left != '0);
      end
    end
  end

endmodule

// File: src/oave_i2f.sv
module oave_i2f
  import oave_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  parse_res_t res,
  input  logic       res_valid,
  output logic       res_ready,
  oave_out_if.source result
);

  logic        s1_valid, s1_adv;
  parse_res_t  s1;
  logic        s2_valid, s2_adv;
  logic        s2_ok, s2_int, s2_sign;
  logic [31:0] s2_raw, s2_mag;
  logic [4:0]  s2_lz;
  logic [31:0] held_value, held_value_next;

  logic        sign;
  logic [31:0] mag, norm, fbits, val;
  logic [4:0]  lz;
  logic        round_up;

  assign s2_adv    = s2_valid && (!result.valid || result.ready);
  assign s1_adv    = s1_valid && (!s2_valid || s2_adv);
  assign res_ready = !s1_valid || s1_adv;

  // magnitude and leading zero count
  always_comb begin
    sign = s1.is_int && s1.raw[31];
    mag  = sign ? (~s1.raw + 32'd1) : s1.raw;
    lz   = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lz = 5'(31 - i);
    end
  end

  // normalise, round to nearest even, pack; floats pass, Inf/NaN give +0
  always_comb begin
    norm     = s2_mag << s2_lz;
    round_up = norm[7] && ((|norm[6:0]) || norm[8]);
    if (!s2_int) begin
      fbits = s2_raw;
    end else if (s2_mag == '0) begin
      fbits = '0;
    end else begin
      fbits = {s2_sign, 8'(8'd158 - {3'b000, s2_lz}), norm[30:8]} + {31'd0, round_up};
    end
    val = (fbits[30:23] == 8'hFF) ? '0 : fbits;
    held_value_next = s2_ok ? val : held_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result.valid <= 1'b0;
      held_value   <= '0;
    end else begin
      if (res_ready) s1_valid <= res_valid;
      if (!s2_valid || s2_adv) s2_valid <= s1_valid;
      if (!result.valid || result.ready) result.valid <= s2_valid;
      if (s2_adv) held_value <= held_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) s1 <= res;
    if (s1_adv) begin
      s2_ok   <= s1.ok;
      s2_int  <= s1.is_int;
      s2_sign <= sign;
      s2_raw  <= s1.raw;
      s2_mag  <= mag;
      s2_lz   <= lz;
    end
    if (s2_adv) begin
      result.updated    <= s2_ok;
      result.value_bits <= held_value_next;
    end
  end

endmodule

// File: src/osc_address_value_extractor.sv
// channel | dir | payload                      | transaction
// stream  | in  | packet_byte[7:0], last_byte  | one datagram byte
// result  | out | updated, value_bits[31:0]    | one per datagram, on its last byte
// cfg     | in  | index[2:0], data[63:0]       | one register write, always ready
//
// One byte per cycle unless a stalled result holds back a last byte;
// the parser updates its state on every byte. A result passes the input
// reg, the parser, then two conversion stages into the output reg.
// Reset clears the held value to +0.0 and restores the default name.
// A stalled result only blocks the stream once a later last byte reaches it.
module osc_address_value_extractor
  import oave_pkg::*;
#(
  parameter int MAX_PACKET = DEF_MAX_PACKET,
  parameter int MAX_NAME   = DEF_MAX_NAME,
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  oave_in_if.sink    stream,
  oave_out_if.source result,
  oave_cfg_if.sink   cfg
);

  name_cfg_t  name_cfg;
  parse_res_t res;
  logic       res_valid;
  logic       res_ready;

  oave_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .name_cfg (name_cfg)
  );

  oave_parser #(
    .MAX_PACKET (MAX_PACKET),
    .MAX_NAME   (MAX_NAME),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .name_cfg  (name_cfg),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  oave_i2f u_i2f (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .result    (result)
  );

endmodule

// File: tb/tb_osc_address_value_extractor.sv
`timescale 1ns / 1ps

module tb_osc_address_value_extractor;
  import oave_pkg::*;

  typedef logic [7:0] bq_t[$];

  typedef struct {
    logic [7:0] pbyte;
    logic       last;
  } stim_t;

  typedef struct {
    logic        updated;
    logic [31:0] value_bits;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  oave_in_if  s_if ();
  oave_out_if r_if ();
  oave_cfg_if c_if ();

  osc_address_value_extractor i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (s_if),
    .result (r_if),
    .cfg    (c_if)
  );

  always #2 clk = ~clk;

  stim_t stim_q[$];
  res_t  exp_res_q[$];
  int    errs = 0;
  int    tx_idle = 0;
  int    rx_stall = 0;
  bit    press = 1'b0;
  bit    held_off = 1'b0;
  int    hold_cnt = 0;
  logic  in_acc = 1'b0;
  stim_t cur;

  // shadow of the block's configuration and datagram store
  logic [5:0]  cf_len = RST_NAME_LENGTH;
  logic [63:0] cf_chars[4] = '{RST_NAME_CHARS0, 64'd0, 64'd0, 64'd0};
  logic [7:0]  pk[0:DEF_MAX_PACKET-1];
  int          taken = 0;
  logic [31:0] held = 32'd0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errs++;
  endtask

  function automatic logic [7:0] nch(input int k);
    return cf_chars[(k >> 3) & 3][(k & 7) * 8 +: 8];
  endfunction

  function automatic bit rd_str(input int base, input int size, inout int off,
                                output int st, output int ln);
    int e;
    st = 0;
    ln = 0;
    if (off >= size) return 1'b0;
    e = off;
    while (e < size && pk[base + e] != 8'd0) e++;
    if (e >= size) return 1'b0;
    st = base + off;
    ln = e - off;
    off = (e + 4) & ~3;
    return off <= size;
  endfunction

  function automatic bit addr_ok(input int st, input int ln);
    int n;
    bit same;
    n = (cf_len > DEF_MAX_NAME) ? DEF_MAX_NAME : int'(cf_len);
    same = 1'b1;
    if (n == 0) return 1'b0;
    if (ln == n) begin
      for (int k = 0; k < n; k++) if (pk[st + k] != nch(k)) same = 1'b0;
      if (same) return 1'b1;
    end
    if (nch(0) != CHAR_SLASH && ln == n + 1 && pk[st] == CHAR_SLASH) begin
      for (int k = 0; k < n; k++) if (pk[st + 1 + k] != nch(k)) return 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] be32(input int a);
    return {pk[a], pk[a + 1], pk[a + 2], pk[a + 3]};
  endfunction

  // int32 to single, round to nearest even
  function automatic logic [31:0] int_to_single(input logic [31:0] b);
    logic [31:0] m;
    logic [63:0] frac, rem, half;
    int p, sh;
    m = b[31] ? (~b + 32'd1) : b;
    if (m == 32'd0) return 32'd0;
    p = 31;
    while (!m[p]) p--;
    if (p <= 23) begin
      frac = 64'(m) << (23 - p);
    end else begin
      sh = p - 23;
      frac = 64'(m) >> sh;
      rem = 64'(m) & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && frac[0])) frac++;
      if (frac[24]) begin
        frac = frac >> 1;
        p++;
      end
    end
    return {b[31], 8'(p + 127), frac[22:0]};
  endfunction

  function automatic bit msg_value(input int base, input int size,
                                   inout logic [31:0] v);
    int off, as, al, ts, tl;
    logic [7:0] tag;
    logic [31:0] bits;
    off = 0;
    if (!rd_str(base, size, off, as, al)) return 1'b0;
    if (!rd_str(base, size, off, ts, tl)) return 1'b0;
    if (tl == 0 || pk[ts] != CHAR_COMMA) return 1'b0;
    if (!addr_ok(as, al)) return 1'b0;
    if (tl < 2) return 1'b0;
    tag = pk[ts + 1];
    if (tag != CHAR_F && tag != CHAR_I) return 1'b0;
    if (longint'(off) + 4 > size) return 1'b0;
    bits = be32(base + off);
    if (tag == CHAR_I) bits = int_to_single(bits);
    v = bits;
    return 1'b1;
  endfunction

  function automatic bit elem_value(input int base, input int size, input int depth,
                                    inout logic [31:0] v);
    string hs;
    bit is_b, any;
    longint off, esz;
    hs = "#bundle";
    is_b = (size >= 8);
    any = 1'b0;
    if (is_b) for (int k = 0; k < 7; k++) if (pk[base + k] != hs[k]) is_b = 1'b0;
    if (!is_b) return msg_value(base, size, v);
    if (depth >= DEF_MAX_DEPTH) return 1'b0;
    off = 16;
    while (off + 4 <= size) begin
      esz = longint'(be32(base + int'(off)));
      off += 4;
      if (esz == 0 || off + esz > size) return any;
      if (elem_value(base + int'(off), int'(esz), depth + 1, v)) any = 1'b1;
      off += esz;
    end
    return any;
  endfunction

  // stream side: store bytes, predict on each last byte, check each result
  always @(posedge clk) begin
    logic [31:0] v;
    res_t er;
    res_t ne;
    bit ok;
    if (rst) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= s_if.valid && s_if.ready;
      if (s_if.valid && s_if.ready) begin
        if (taken < DEF_MAX_PACKET) begin
          pk[taken] = s_if.packet_byte;
          taken++;
        end
        if (s_if.last_byte) begin
          v = 32'd0;
          ok = elem_value(0, taken, 0, v);
          if (ok) held = (v[30:23] == 8'hFF) ? 32'd0 : v;
          taken = 0;
          ne.updated = ok;
          ne.value_bits = held;
          exp_res_q.insert(exp_res_q.size(), ne);
        end
      end
      if (r_if.valid && r_if.ready) begin
        if (exp_res_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          er = exp_res_q.pop_front();
          if (r_if.updated !== er.updated)
            report($sformatf("updated %0b, want %0b", r_if.updated, er.updated));
          if (r_if.value_bits !== er.value_bits)
            report($sformatf("value_bits %h, want %h", r_if.value_bits, er.value_bits));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_if.valid <= 1'b0;
      s_if.packet_byte <= 8'd0;
      s_if.last_byte <= 1'b0;
    end else if (!s_if.valid || in_acc) begin
      if (stim_q.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
        cur = stim_q.pop_front();
        s_if.valid <= 1'b1;
        s_if.packet_byte <= cur.pbyte;
        s_if.last_byte <= cur.last;
      end else begin
        s_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (press && !held_off) begin
      hold_cnt <= 600;
      held_off <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(negedge clk) begin
    r_if.ready <= !rst && hold_cnt == 0 && $urandom_range(0, 99) >= rx_stall;
  end

  function automatic bq_t pad4(input bq_t q);
    q = {q, 8'd0};
    while (q.size() % 4 != 0) q = {q, 8'd0};
    return q;
  endfunction

  function automatic bq_t be_bytes(input logic [31:0] w);
    bq_t q;
    q = {w[31:24], w[23:16], w[15:8], w[7:0]};
    return q;
  endfunction

  function automatic bq_t bundle_head();
    bq_t q;
    string hs;
    hs = "#bundle";
    for (int k = 0; k < 7; k++) q = {q, 8'(hs[k])};
    q = {q, 8'd0};
    for (int k = 0; k < 8; k++) q = {q, 8'($urandom)};
    return q;
  endfunction

  function automatic bq_t mk_addr(input int mode);
    bq_t q;
    int n;
    n = (cf_len > DEF_MAX_NAME) ? DEF_MAX_NAME : int'(cf_len);
    case (mode)
      0, 1, 3: begin
        if (mode == 1) q = {q, CHAR_SLASH};
        for (int k = 0; k < n; k++) q = {q, nch(k)};
        if (mode == 3 && q.size() != 0) q[$urandom_range(0, q.size() - 1)] ^= 8'h01;
      end
      2: begin
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) q = {q, 8'($urandom_range(33, 126))};
      end
      default: ;
    endcase
    return q;
  endfunction

  function automatic logic [31:0] rand_arg();
    case ($urandom_range(0, 7))
      0: return 32'h7F80_0000 | ($urandom & 32'h807F_FFFF);
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'd0;
      4: return 32'($urandom_range(0, 300)) - 32'd150;
      5: return (32'd1 << $urandom_range(24, 30)) + 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // tmode: 0 ",f", 1 ",i", 2 ",s", 3 ",", 4 "f", 5 ",if"
  function automatic bq_t mk_msg(input int amode, input int tmode, input logic [31:0] arg,
                                 input int trunc);
    bq_t q, t;
    q = pad4(mk_addr(amode));
    if (tmode != 4) t = {t, CHAR_COMMA};
    case (tmode)
      0, 4: t = {t, CHAR_F};
      1: t = {t, CHAR_I};
      2: t = {t, 8'h73};
      5: begin
        t = {t, CHAR_I};
        t = {t, CHAR_F};
      end
      default: ;
    endcase
    q = {q, pad4(t), be_bytes(arg)};
    for (int k = 0; k < trunc && q.size() > 1; k++) void'(q.pop_back());
    return q;
  endfunction

  function automatic bq_t rand_msg();
    int am, tm;
    am = $urandom_range(0, 9);
    am = (am < 5) ? 0 : (am < 7) ? 1 : am - 5;
    tm = $urandom_range(0, 9);
    tm = (tm < 4) ? 0 : (tm < 7) ? 1 : tm - 5;
    return mk_msg(am, tm, rand_arg(), ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0);
  endfunction

  function automatic bq_t mk_bundle(input int lvls);
    bq_t q, e;
    logic [31:0] sz;
    int n;
    q = bundle_head();
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      e = (lvls > 0 && $urandom_range(0, 3) == 0) ? mk_bundle(lvls - 1) : rand_msg();
      sz = e.size();
      case ($urandom_range(0, 15))
        0: sz = 32'd0;
        1: sz = sz + $urandom_range(1, 100);
        2: sz = $urandom;
        default: ;
      endcase
      q = {q, be_bytes(sz), e};
    end
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) q = {q, 8'($urandom)};
    return q;
  endfunction

  function automatic bq_t mk_nest(input int k, input logic [31:0] v);
    bq_t e;
    if (k == 0) return mk_msg(0, 0, v, 0);
    e = mk_nest(k - 1, v);
    return {bundle_head(), be_bytes(e.size()), e};
  endfunction

  function automatic bq_t mk_noise();
    bq_t q;
    if ($urandom_range(0, 1)) q = bundle_head();
    repeat ($urandom_range(1, 30)) q = {q, 8'($urandom)};
    return q;
  endfunction

  task automatic send_dgram(input bq_t d);
    stim_t s;
    foreach (d[i]) begin
      s.pbyte = d[i];
      s.last = (i == d.size() - 1);
      stim_q.insert(stim_q.size(), s);
    end
  endtask

  task automatic send_random(input int nbytes);
    bq_t d;
    int sent, r;
    sent = 0;
    while (sent < nbytes) begin
      r = $urandom_range(0, 9);
      if (r < 5) d = rand_msg();
      else if (r < 8) d = mk_bundle(2);
      else if (r < 9) d = mk_nest($urandom_range(7, 9), rand_arg());
      else d = mk_noise();
      send_dgram(d);
      sent += d.size();
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (stim_q.size() != 0 || s_if.valid || exp_res_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    c_if.valid <= 1'b1;
    c_if.index <= idx;
    c_if.data <= val;
    @(posedge clk);
    while (!c_if.ready) @(posedge clk);
    case (idx)
      CFG_NAME_LENGTH: cf_len = val[5:0];
      CFG_NAME_CHARS0: cf_chars[0] = val;
      CFG_NAME_CHARS1: cf_chars[1] = val;
      CFG_NAME_CHARS2: cf_chars[2] = val;
      CFG_NAME_CHARS3: cf_chars[3] = val;
      default: ;
    endcase
    @(negedge clk);
    c_if.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_chars();
    logic [63:0] w;
    for (int k = 0; k < 8; k++) w[k * 8 +: 8] = 8'($urandom_range(33, 126));
    return w;
  endfunction

  initial begin
    bq_t d, e;
    s_if.valid = 1'b0;
    s_if.packet_byte = 8'd0;
    s_if.last_byte = 1'b0;
    r_if.ready = 1'b0;
    c_if.valid = 1'b0;
    c_if.index = CFG_NAME_LENGTH;
    c_if.data = 64'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, default name
    send_dgram(mk_msg(0, 0, 32'h3F80_0000, 0));
    send_dgram(mk_msg(0, 1, 32'h8000_0000, 0));
    send_dgram(mk_msg(0, 1, 32'h7FFF_FFFF, 0));
    send_dgram(mk_msg(0, 1, 32'h0100_0003, 0));
    send_dgram(mk_msg(0, 0, 32'h7F80_0000, 0));
    send_dgram(mk_msg(0, 0, 32'hFFC0_0001, 0));
    send_dgram(mk_msg(0, 0, 32'hFFFF_FFFF, 0));
    send_dgram(mk_msg(0, 1, 32'd0, 0));
    send_dgram(mk_msg(3, 0, 32'h4000_0000, 0));
    send_dgram(mk_msg(4, 0, 32'h4000_0000, 0));
    send_dgram(mk_msg(0, 2, 32'h4000_0000, 0));
    send_dgram(mk_msg(0, 3, 32'h4000_0000, 0));
    send_dgram(mk_msg(0, 4, 32'h4000_0000, 0));
    send_dgram(mk_msg(0, 0, 32'h4000_0000, 2));
    d = mk_msg(0, 0, 32'h4040_0000, 0);
    d = {bundle_head(), be_bytes(d.size()), d, be_bytes(32'd0), d};
    send_dgram(d);
    d = mk_msg(0, 0, 32'h4080_0000, 0);
    d = {bundle_head(), be_bytes(d.size()), d, be_bytes(32'd200), d};
    send_dgram(d);
    // deepest allowed nesting, then one level too deep, then past the store size
    d = mk_nest(7, 32'h4100_0000);
    e = mk_nest(8, 32'h4200_0000);
    d = {bundle_head(), be_bytes(d.size()), d, be_bytes(e.size()), e};
    while (d.size() < 1540) d = {d, 8'($urandom)};
    send_dgram(d);
    d = {8'hFF};
    send_dgram(d);
    drain();

    // short name without slash, sender gaps
    write_reg(CFG_NAME_LENGTH, 64'd1);
    write_reg(CFG_NAME_CHARS0, 64'h78);
    write_reg(CFG_NAME_CHARS1, rand_chars());
    write_reg(CFG_NAME_CHARS2, rand_chars());
    write_reg(CFG_NAME_CHARS3, rand_chars());
    tx_idle = 52;
    send_random(80);
    drain();

    // full-length name with slash, receiver stalls
    write_reg(CFG_NAME_LENGTH, 64'd32);
    write_reg(CFG_NAME_CHARS0, (rand_chars() << 8) | 64'(CHAR_SLASH));
    tx_idle = 0;
    rx_stall = 52;
    send_random(80);
    drain();

    // over-long length, random name, both sides idle, long receiver hold-off
    write_reg(CFG_NAME_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_NAME_CHARS0, rand_chars());
    tx_idle = 30;
    rx_stall = 30;
    repeat (8) send_dgram(mk_msg(0, 1, rand_arg(), 0));
    press = 1'b1;
    send_random(60);
    drain();

    // empty name never matches
    write_reg(CFG_NAME_LENGTH, 64'd0);
    tx_idle = 0;
    rx_stall = 0;
    send_random(40);
    drain();

    if (exp_res_q.size() != 0) report("expected results left over");
    if (errs == 0) begin
      $display("tb_osc_address_value_extractor OK");
    end else begin
      $display("tb_osc_address_value_extractor NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_osc_address_value_extractor NOT OK");
    $finish;
  end

endmodule

// File: files.f
src/oave_pkg.sv
src/oave_if.sv
src/oave_cfg_regs.sv
src/oave_parser.sv
src/oave_i2f.sv
src/osc_address_value_extractor.sv
tb/tb_osc_address_value_extractor.sv
